[hdl/env_sensor_compensation_unit_assert.svh]
// ============================================================================
// Assertion macros for the environmental sensor compensation unit
// Clocked implication checks, immediate and delayed, with reset disable.
// ============================================================================
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define ESCU_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

[hdl/escu_pkg.sv]
// ============================================================================
// escu_pkg
// Shared types, constants and stage counts for the compensation pipeline.
// ============================================================================
package escu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_TEMP      = 3'd0,
        CFG_CAL_PRESS_LO  = 3'd1,
        CFG_CAL_PRESS_MID = 3'd2,
        CFG_CAL_PRESS_HI  = 3'd3,
        CFG_CAL_HUM_A     = 3'd4,
        CFG_CAL_HUM_B     = 3'd5
    } t_cfg_idx;

    // fine temperature is truncated to TF_W signed bits, within -2^23 .. 2^23-1
    localparam int TF_W   = 24;
    localparam int DEN_W  = 40;
    localparam int UN_W   = 61;
    localparam int QUOT_W = 37;
    localparam int DVD_W  = UN_W + 12;
    localparam int Q_W    = QUOT_W + 1;

    localparam logic [QUOT_W-1:0] QUOT_MAX = '1;

    localparam int TF_PRESS_OFS = 128000;
    localparam int TF_HUM_OFS   = 76800;
    localparam int PRESS_FULL   = 1048576;
    localparam int PRESS_SCALE  = 3125;
    localparam int HUM_CLAMP    = 419430400;
    localparam int HUM_ROUND_A  = 16384;
    localparam int HUM_BIAS     = 2097152;
    localparam int HUM_HALF     = 32768;
    localparam int HUM_ROUND_C  = 8192;

    localparam logic [16:0] HUM_MAX_Q = 17'd102400;

    localparam int TEMP_STAGES  = 3;
    localparam int FRONT_STAGES = 7;
    localparam int POST_STAGES  = 3;
    localparam int PIPE_DEPTH   = TEMP_STAGES + FRONT_STAGES + QUOT_W + POST_STAGES;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_meas;

    typedef struct packed {
        logic signed [17:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               press_invalid;
        logic [16:0]        hum_q22_10;
    } t_result;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [15:0] h4;
        logic signed [15:0] h5;
        logic signed [7:0]  h6;
    } t_cal;

    typedef struct packed {
        logic signed [17:0] temp_centi;
        logic [16:0]        hum;
        logic               inv;
        logic               neg;
        logic               sat;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [QUOT_W-1:0] low;
        logic [QUOT_W-1:0] quot;
        logic [DEN_W-1:0]  ud;
        t_side             side;
    } t_div;

endpackage

[hdl/escu_temp.sv]
// ============================================================================
// escu_temp
// Three-stage temperature compensation: fine temperature and 0.01 degC value.
// ============================================================================
module escu_temp import escu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  t_meas                  i_meas,
    input  t_cal                   i_cal,
    output logic                   o_vld,
    output logic signed [TF_W-1:0] o_tf,
    output logic signed [17:0]     o_temp,
    output logic [19:0]            o_raw_press,
    output logic [15:0]            o_raw_hum
);

    logic [TEMP_STAGES-1:0] r_vld;

    logic signed [18:0] d1;
    logic signed [17:0] d2;
    logic signed [34:0] n1_m1;
    logic signed [35:0] n1_m2;
    logic signed [34:0] r1_m1;
    logic signed [35:0] r1_m2;
    logic [19:0]        r1_rp;
    logic [15:0]        r1_rh;

    logic signed [23:0] m2s;
    logic signed [39:0] n2_m3;
    logic signed [23:0] r2_m1s;
    logic signed [39:0] r2_m3;
    logic [19:0]        r2_rp;
    logic [15:0]        r2_rh;

    logic signed [26:0]     tf_full;
    logic signed [TF_W-1:0] n3_tf;
    logic signed [27:0]     t5;
    logic signed [TF_W-1:0] r3_tf;
    logic signed [17:0]     r3_temp;
    logic [19:0]            r3_rp;
    logic [15:0]            r3_rh;

    always_comb begin
        d1    = $signed({2'b00, i_meas.raw_temp[19:3]}) - $signed({2'b00, i_cal.t1, 1'b0});
        d2    = $signed({2'b00, i_meas.raw_temp[19:4]}) - $signed({2'b00, i_cal.t1});
        n1_m1 = d1 * i_cal.t2;
        n1_m2 = d2 * d2;
        m2s   = r1_m2[35:12];
        n2_m3 = m2s * i_cal.t3;
        tf_full = 27'(r2_m1s) + 27'($signed(r2_m3[39:14]));
        n3_tf   = tf_full[TF_W-1:0];
        t5      = 28'(n3_tf) * 28'sd5 + 28'sd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TEMP_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m1   <= n1_m1;
        r1_m2   <= n1_m2;
        r1_rp   <= i_meas.raw_press;
        r1_rh   <= i_meas.raw_hum;
        r2_m1s  <= r1_m1[34:11];
        r2_m3   <= n2_m3;
        r2_rp   <= r1_rp;
        r2_rh   <= r1_rh;
        r3_tf   <= n3_tf;
        r3_temp <= t5[25:8];
        r3_rp   <= r2_rp;
        r3_rh   <= r2_rh;
    end

    assign o_vld       = r_vld[TEMP_STAGES-1];
    assign o_tf        = r3_tf;
    assign o_temp      = r3_temp;
    assign o_raw_press = r3_rp;
    assign o_raw_hum   = r3_rh;

endmodule

[hdl/escu_front.sv]
// ============================================================================
// escu_front
// Seven stages: pressure numerator and divisor, scaled dividend, humidity.
// ============================================================================
module escu_front import escu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic signed [TF_W-1:0] i_tf,
    input  logic signed [17:0]     i_temp,
    input  logic [19:0]            i_raw_press,
    input  logic [15:0]            i_raw_hum,
    input  t_cal                   i_cal,
    output logic                   o_vld,
    output t_div                   o_div
);

    logic [FRONT_STAGES-1:0] r_vld;

    // stage 1
    logic signed [24:0] v;
    logic signed [24:0] x;
    logic signed [47:0] r1_vv;
    logic signed [40:0] r1_vp2, r1_vp5, r1_h5x;
    logic signed [32:0] r1_xh6;
    logic signed [33:0] r1_xh3;
    logic [19:0]        r1_rp;
    logic [15:0]        r1_rh;
    logic signed [17:0] r1_temp;

    // stage 2
    logic signed [43:0] ha_sum;
    logic signed [22:0] a6;
    logic signed [23:0] b3;
    logic signed [63:0] r2_vvp6, r2_vvp3;
    logic signed [40:0] r2_vp2, r2_vp5;
    logic signed [28:0] r2_ha;
    logic signed [46:0] r2_hbm;
    logic [19:0]        r2_rp;
    logic signed [17:0] r2_temp;

    // stage 3
    logic signed [63:0] a_full;
    logic signed [37:0] hb;
    logic signed [63:0] r3_e2;
    logic signed [55:0] r3_a;
    logic signed [53:0] r3_hbh2;
    logic signed [28:0] r3_ha;
    logic [19:0]        r3_rp;
    logic signed [17:0] r3_temp;

    // stage 4
    logic signed [72:0] den_prod;
    logic [20:0]        rp_diff;
    logic signed [53:0] hc_sum;
    logic signed [DEN_W-1:0] r4_den;
    logic signed [63:0] r4_num;
    logic signed [39:0] r4_hc;
    logic signed [28:0] r4_ha;
    logic signed [17:0] r4_temp;

    // stage 5
    logic signed [63:0] num_neg;
    logic signed [DEN_W-1:0] den_neg;
    logic [UN_W-1:0]    r5_un;
    logic [DEN_W-1:0]   r5_ud;
    logic               r5_neg, r5_inv;
    logic signed [63:0] r5_hv;
    logic signed [17:0] r5_temp;

    // stage 6
    logic signed [28:0] w29;
    logic [DVD_W-1:0]   r6_dvd;
    logic [57:0]        r6_ww;
    logic               r6_big;
    logic signed [63:0] r6_hv;
    logic [DEN_W-1:0]   r6_ud;
    logic               r6_neg, r6_inv;
    logic signed [17:0] r6_temp;

    // stage 7
    logic [58:0]        hmul;
    logic signed [63:0] hv2;
    logic [28:0]        hum_c;
    t_div               n_div;
    t_div               r_div;

    always_comb begin
        v = 25'(i_tf) - 25'(TF_PRESS_OFS);
        x = 25'(i_tf) - 25'(TF_HUM_OFS);

        ha_sum = 44'($signed({1'b0, r1_rh, 14'b0})) - (44'(i_cal.h4) <<< 20)
               - 44'(r1_h5x) + 44'(HUM_ROUND_A);
        a6 = r1_xh6[32:10];
        b3 = 24'($signed(r1_xh3[33:11])) + 24'(HUM_HALF);

        a_full = (r2_vvp3 >>> 8) + (64'(r2_vp2) <<< 12) + 64'sd140737488355328;
        hb     = 38'($signed(r2_hbm[46:10])) + 38'(HUM_BIAS);

        den_prod = r3_a * $signed({1'b0, i_cal.p1});
        rp_diff  = 21'(PRESS_FULL) - {1'b0, r3_rp};
        hc_sum   = r3_hbh2 + 54'(HUM_ROUND_C);

        num_neg = -r4_num;
        den_neg = -r4_den;

        w29 = r5_hv[43:15];

        hmul = r6_ww[57:7] * i_cal.h1;
        if (i_cal.h1 == 8'd0) begin
            hv2 = r6_hv;
        end else if (r6_big) begin
            hv2 = '0;
        end else begin
            hv2 = r6_hv - $signed(64'(hmul[58:4]));
        end
        if (hv2 < 0) begin
            hum_c = '0;
        end else if (hv2 > 64'(HUM_CLAMP)) begin
            hum_c = 29'(HUM_CLAMP);
        end else begin
            hum_c = hv2[28:0];
        end

        n_div.rem             = DEN_W'(r6_dvd[DVD_W-1:QUOT_W]);
        n_div.low             = r6_dvd[QUOT_W-1:0];
        n_div.quot            = '0;
        n_div.ud              = r6_ud;
        n_div.side.temp_centi = r6_temp;
        n_div.side.hum        = hum_c[28:12];
        n_div.side.inv        = r6_inv;
        n_div.side.neg        = r6_neg;
        // quotient of 2^37 or more pins to the maximum
        n_div.side.sat        = (DEN_W'(r6_dvd[DVD_W-1:QUOT_W]) >= r6_ud);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_vv   <= v * v;
        r1_vp2  <= v * i_cal.p2;
        r1_vp5  <= v * i_cal.p5;
        r1_h5x  <= x * i_cal.h5;
        r1_xh6  <= x * i_cal.h6;
        r1_xh3  <= x * $signed({1'b0, i_cal.h3});
        r1_rp   <= i_raw_press;
        r1_rh   <= i_raw_hum;
        r1_temp <= i_temp;

        r2_vvp6 <= r1_vv * i_cal.p6;
        r2_vvp3 <= r1_vv * i_cal.p3;
        r2_vp2  <= r1_vp2;
        r2_vp5  <= r1_vp5;
        r2_ha   <= ha_sum[43:15];
        r2_hbm  <= a6 * b3;
        r2_rp   <= r1_rp;
        r2_temp <= r1_temp;

        r3_e2   <= r2_vvp6 + (64'(r2_vp5) <<< 17) + (64'(i_cal.p4) <<< 35);
        r3_a    <= a_full[55:0];
        r3_hbh2 <= hb * i_cal.h2;
        r3_ha   <= r2_ha;
        r3_rp   <= r2_rp;
        r3_temp <= r2_temp;

        r4_den  <= den_prod[72:33];
        r4_num  <= (64'($signed({1'b0, rp_diff})) <<< 31) - r3_e2;
        r4_hc   <= hc_sum[53:14];
        r4_ha   <= r3_ha;
        r4_temp <= r3_temp;

        r5_un   <= r4_num[63] ? num_neg[UN_W-1:0] : r4_num[UN_W-1:0];
        r5_ud   <= r4_den[DEN_W-1] ? den_neg : r4_den;
        r5_neg  <= r4_num[63] ^ r4_den[DEN_W-1];
        r5_inv  <= (r4_den == '0);
        r5_hv   <= r4_ha * r4_hc;
        r5_temp <= r4_temp;

        r6_dvd  <= r5_un * DVD_W'(PRESS_SCALE);
        r6_ww   <= w29 * w29;
        // drop the humidity when the squared term leaves 29 bits
        r6_big  <= !((&r5_hv[63:43]) || !(|r5_hv[63:43]))
                 || (r5_hv[43:15] == {1'b1, 28'b0});
        r6_hv   <= r5_hv;
        r6_ud   <= r5_ud;
        r6_neg  <= r5_neg;
        r6_inv  <= r5_inv;
        r6_temp <= r5_temp;

        r_div   <= n_div;
    end

    assign o_vld = r_vld[FRONT_STAGES-1];
    assign o_div = r_div;

endmodule

[hdl/escu_div.sv]
// ============================================================================
// escu_div
// Restoring divider, one quotient bit per pipeline stage.
// ============================================================================
module escu_div import escu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_div i_div,
    output logic o_vld,
    output t_div o_div
);

    t_div w_stg [0:QUOT_W];
    logic w_vld [0:QUOT_W];

    assign w_stg[0] = i_div;
    assign w_vld[0] = i_vld;

    for (genvar g = 0; g < QUOT_W; g++) begin : g_bit
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             ge;
        t_div             n_q;
        t_div             r_q;
        logic             r_v;

        always_comb begin
            shifted    = {w_stg[g].rem, w_stg[g].low[QUOT_W-1]};
            diff       = shifted - {1'b0, w_stg[g].ud};
            ge         = (shifted >= {1'b0, w_stg[g].ud});
            n_q        = w_stg[g];
            n_q.rem    = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_q.low    = {w_stg[g].low[QUOT_W-2:0], 1'b0};
            n_q.quot   = {w_stg[g].quot[QUOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q <= n_q;
        end

        assign w_stg[g+1] = r_q;
        assign w_vld[g+1] = r_v;
    end

    assign o_vld = w_vld[QUOT_W];
    assign o_div = w_stg[QUOT_W];

endmodule

[hdl/escu_post.sv]
// ============================================================================
// escu_post
// Three-stage pressure polynomial, range clamp and result register.
// ============================================================================
module escu_post import escu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_div    i_div,
    input  t_cal    i_cal,
    output logic    o_stb,
    output t_result o_res
);

    logic [POST_STAGES-2:0] r_vld;

    logic [QUOT_W-1:0]     qm;
    logic signed [Q_W-1:0] q;
    logic signed [24:0]    s;
    logic signed [Q_W-1:0] r1_q;
    logic signed [24:0]    r1_s;
    logic signed [40:0]    r1_p9s;
    logic signed [53:0]    r1_p8q;
    t_side                 r1_side;

    logic signed [65:0]    f1_prod;
    logic signed [Q_W-1:0] r2_q;
    logic signed [40:0]    r2_f1;
    logic signed [34:0]    r2_f2;
    t_side                 r2_side;

    logic signed [42:0]    sum;
    logic signed [35:0]    r;
    t_result               n_res;
    t_result               r_res;
    logic                  r_stb;

    always_comb begin
        qm = i_div.side.sat ? QUOT_MAX : i_div.quot;
        q  = i_div.side.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        s  = q[Q_W-1:13];

        f1_prod = r1_p9s * r1_s;

        sum = 43'(r2_q) + 43'(r2_f1) + 43'(r2_f2);
        r   = 36'($signed(sum[42:8])) + (36'(i_cal.p7) <<< 4);

        n_res.temp_centi    = r2_side.temp_centi;
        n_res.hum_q22_10    = r2_side.hum;
        n_res.press_invalid = r2_side.inv;
        if (r2_side.inv || r < 0) begin
            n_res.press_q24_8 = '0;
        end else if (r > 36'sh0FFFFFFFF) begin
            n_res.press_q24_8 = '1;
        end else begin
            n_res.press_q24_8 = r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_stb <= 1'b0;
        end else begin
            r_vld <= {r_vld[POST_STAGES-3:0], i_vld};
            r_stb <= r_vld[POST_STAGES-2];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_q    <= q;
        r1_s    <= s;
        r1_p9s  <= i_cal.p9 * s;
        r1_p8q  <= i_cal.p8 * q;
        r1_side <= i_div.side;
        r2_q    <= r1_q;
        r2_f1   <= f1_prod[65:25];
        r2_f2   <= r1_p8q[53:19];
        r2_side <= r1_side;
        r_res   <= n_res;
    end

    assign o_stb = r_stb;
    assign o_res = r_res;

endmodule

[hdl/env_sensor_compensation_unit.sv]
// ============================================================================
// env_sensor_compensation_unit: temperature, pressure and humidity compensation
// Stages in order: escu_temp, escu_front, escu_div and escu_post; one transaction per cycle.
// Depth is set by the 37-stage pressure divider, one quotient bit per stage.
// busy stays low; results are strobed for one cycle and cannot be held off.
// Synchronous active-low reset clears pipeline valids and calibration to zero.
// ============================================================================
module env_sensor_compensation_unit import escu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_meas                 i_meas,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_res_stb,
    output t_result               o_res
);

`include "env_sensor_compensation_unit_assert.svh"

    // Calibration registers, laid out as they are written
    logic [47:0] r_cal_temp;
    logic [47:0] r_cal_press_lo;
    logic [47:0] r_cal_press_mid;
    logic [47:0] r_cal_press_hi;
    logic [31:0] r_cal_hum_a;
    logic [39:0] r_cal_hum_b;
    t_cal        cal;

    logic                   accept;
    logic                   tmp_vld;
    logic signed [TF_W-1:0] tmp_tf;
    logic signed [17:0]     tmp_temp;
    logic [19:0]            tmp_rp;
    logic [15:0]            tmp_rh;
    logic                   frt_vld;
    t_div                   frt_div;
    logic                   div_vld;
    t_div                   div_out;

    // Every stage advances every cycle, so a new transaction is always taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Register file: a write is registered and visible from the next cycle; unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp      <= '0;
            r_cal_press_lo  <= '0;
            r_cal_press_mid <= '0;
            r_cal_press_hi  <= '0;
            r_cal_hum_a     <= '0;
            r_cal_hum_b     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CAL_TEMP:      r_cal_temp      <= i_cfg_wdata;
                CFG_CAL_PRESS_LO:  r_cal_press_lo  <= i_cfg_wdata;
                CFG_CAL_PRESS_MID: r_cal_press_mid <= i_cfg_wdata;
                CFG_CAL_PRESS_HI:  r_cal_press_hi  <= i_cfg_wdata;
                CFG_CAL_HUM_A:     r_cal_hum_a     <= i_cfg_wdata[31:0];
                CFG_CAL_HUM_B:     r_cal_hum_b     <= i_cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    // Split the packed words into individual coefficients
    always_comb begin
        cal.t1 = r_cal_temp[15:0];
        cal.t2 = r_cal_temp[31:16];
        cal.t3 = r_cal_temp[47:32];
        cal.p1 = r_cal_press_lo[15:0];
        cal.p2 = r_cal_press_lo[31:16];
        cal.p3 = r_cal_press_lo[47:32];
        cal.p4 = r_cal_press_mid[15:0];
        cal.p5 = r_cal_press_mid[31:16];
        cal.p6 = r_cal_press_mid[47:32];
        cal.p7 = r_cal_press_hi[15:0];
        cal.p8 = r_cal_press_hi[31:16];
        cal.p9 = r_cal_press_hi[47:32];
        cal.h1 = r_cal_hum_a[7:0];
        cal.h2 = r_cal_hum_a[23:8];
        cal.h3 = r_cal_hum_a[31:24];
        cal.h4 = r_cal_hum_b[15:0];
        cal.h5 = r_cal_hum_b[31:16];
        cal.h6 = r_cal_hum_b[39:32];
    end

    // Fine temperature first: both other channels depend on it
    escu_temp u_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (accept),
        .i_meas      (i_meas),
        .i_cal       (cal),
        .o_vld       (tmp_vld),
        .o_tf        (tmp_tf),
        .o_temp      (tmp_temp),
        .o_raw_press (tmp_rp),
        .o_raw_hum   (tmp_rh)
    );

    // Pressure numerator/divisor and the whole humidity path
    escu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (tmp_vld),
        .i_tf        (tmp_tf),
        .i_temp      (tmp_temp),
        .i_raw_press (tmp_rp),
        .i_raw_hum   (tmp_rh),
        .i_cal       (cal),
        .o_vld       (frt_vld),
        .o_div       (frt_div)
    );

    // Pressure quotient; temperature and humidity ride alongside
    escu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (frt_vld),
        .i_div   (frt_div),
        .o_vld   (div_vld),
        .o_div   (div_out)
    );

    // Pressure correction terms, clamping and the output register
    escu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .i_div   (div_out),
        .i_cal   (cal),
        .o_stb   (o_res_stb),
        .o_res   (o_res)
    );

    // Each accepted transaction yields its result strobe at the end of the pipeline
    `ESCU_ASSERT_DLY(a_latency, i_clk, i_rst_n, accept, PIPE_DEPTH, o_res_stb, "result strobe missing")
    `ESCU_ASSERT_IMP(a_no_ghost, i_clk, i_rst_n, o_res_stb, $past(accept, PIPE_DEPTH), "result without transaction")
    `ESCU_ASSERT_IMP(a_inv_zero, i_clk, i_rst_n, o_res_stb && o_res.press_invalid, o_res.press_q24_8 == '0, "invalid pressure not zero")
    `ESCU_ASSERT_IMP(a_hum_range, i_clk, i_rst_n, o_res_stb, o_res.hum_q22_10 <= HUM_MAX_Q, "humidity above full scale")

endmodule

[sim/env_sensor_compensation_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// env_sensor_compensation_unit_tb: self-checking bench for the compensation unit
// Drives raw measurements under several calibration sets and idle patterns,
// predicts every compensated result in-bench and checks each strobed result.
// ============================================================================
module env_sensor_compensation_unit_tb;
    import escu_pkg::*;

    localparam longint QUOT_LIMIT = 64'sd137438953471;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_meas                 i_meas;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_res_stb;
    t_result               o_res;

    env_sensor_compensation_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_meas     (i_meas),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_res_stb  (o_res_stb),
        .o_res      (o_res)
    );

    // Bench copy of the calibration registers, indexed like the write port
    logic [47:0] cal_shadow [0:5];
    t_result     pending_results [$];
    int          mismatches;
    int          sent_count;
    int          checked_count;
    int          invalid_seen;
    int          sender_idle_pct;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ------------------------------------------------------------------------
    // Compensation predictor
    // ------------------------------------------------------------------------
    function automatic longint sx16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sx8(logic [7:0] v);
        return longint'($signed(v));
    endfunction

    function automatic t_result compensate(t_meas m);
        t_result res;
        longint rt, rp, rh, t1, t2, t3, d1, d2, tf, temp;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint v, e1, e2, a, den, num, q, s, f1, f2, r;
        longint unsigned a_lo, un, ud, qh, ql, qm;
        longint h1, h2, h3, h4, h5, h6, x, ha, hb, hc, hv, w;
        logic neg;
        rt = longint'(m.raw_temp);
        rp = longint'(m.raw_press);
        rh = longint'(m.raw_hum);

        // temperature and the fine temperature shared by the other paths
        t1 = longint'(cal_shadow[CFG_CAL_TEMP][15:0]);
        t2 = sx16(cal_shadow[CFG_CAL_TEMP][31:16]);
        t3 = sx16(cal_shadow[CFG_CAL_TEMP][47:32]);
        d1 = (rt >>> 3) - 2 * t1;
        d2 = (rt >>> 4) - t1;
        tf = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
        temp = (tf * 5 + 128) >>> 8;

        // pressure
        p1 = longint'(cal_shadow[CFG_CAL_PRESS_LO][15:0]);
        p2 = sx16(cal_shadow[CFG_CAL_PRESS_LO][31:16]);
        p3 = sx16(cal_shadow[CFG_CAL_PRESS_LO][47:32]);
        p4 = sx16(cal_shadow[CFG_CAL_PRESS_MID][15:0]);
        p5 = sx16(cal_shadow[CFG_CAL_PRESS_MID][31:16]);
        p6 = sx16(cal_shadow[CFG_CAL_PRESS_MID][47:32]);
        p7 = sx16(cal_shadow[CFG_CAL_PRESS_HI][15:0]);
        p8 = sx16(cal_shadow[CFG_CAL_PRESS_HI][31:16]);
        p9 = sx16(cal_shadow[CFG_CAL_PRESS_HI][47:32]);
        v  = tf - 128000;
        e2 = v * v * p6 + v * p5 * 131072 + p4 * 64'sd34359738368;
        e1 = ((v * v * p3) >>> 8) + v * p2 * 4096;
        a  = 64'sd140737488355328 + e1;
        a_lo = longint'(a) & 64'h1_FFFF_FFFF;
        den = (a >>> 33) * p1 + longint'((a_lo * longint'(p1)) >> 33);
        res.press_q24_8   = '0;
        res.press_invalid = 1'b0;
        if (den == 0) begin
            res.press_invalid = 1'b1;
        end else begin
            num = (1048576 - rp) * 64'sd2147483648 - e2;
            neg = (num < 0) != (den < 0);
            un  = (num < 0) ? -num : num;
            ud  = (den < 0) ? -den : den;
            qh  = un / ud;
            ql  = un % ud;
            // saturate the scaled quotient rather than let it grow
            if (qh > QUOT_LIMIT / 3125) begin
                qm = QUOT_LIMIT;
            end else begin
                qm = qh * 3125 + (ql * 3125) / ud;
                if (qm > QUOT_LIMIT) qm = QUOT_LIMIT;
            end
            q  = neg ? -longint'(qm) : longint'(qm);
            s  = q >>> 13;
            f1 = ((p9 * s) * s) >>> 25;
            f2 = (p8 * q) >>> 19;
            r  = ((q + f1 + f2) >>> 8) + p7 * 16;
            if (r < 0)                     res.press_q24_8 = '0;
            else if (r > 64'sd4294967295)  res.press_q24_8 = '1;
            else                           res.press_q24_8 = r[31:0];
        end

        // humidity, clamped before the final scaling
        h1 = longint'(cal_shadow[CFG_CAL_HUM_A][7:0]);
        h2 = sx16(cal_shadow[CFG_CAL_HUM_A][23:8]);
        h3 = longint'(cal_shadow[CFG_CAL_HUM_A][31:24]);
        h4 = sx16(cal_shadow[CFG_CAL_HUM_B][15:0]);
        h5 = sx16(cal_shadow[CFG_CAL_HUM_B][31:16]);
        h6 = sx8(cal_shadow[CFG_CAL_HUM_B][39:32]);
        x  = tf - 76800;
        ha = (rh * 16384 - h4 * 1048576 - h5 * x + 16384) >>> 15;
        hb = ((((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768)) >>> 10) + 2097152;
        hc = (hb * h2 + 8192) >>> 14;
        hv = ha * hc;
        if (h1 != 0) begin
            w = hv >>> 15;
            if (w >= 64'sd268435456 || w <= -64'sd268435456) hv = 0;
            else hv = hv - ((((w * w) >>> 7) * h1) >>> 4);
        end
        if (hv < 0) hv = 0;
        if (hv > 419430400) hv = 419430400;

        res.temp_centi = temp[17:0];
        res.hum_q22_10 = hv[28:12];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: outputs change at the rising edge, so sample mid-cycle
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 checked_count, what, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_stb) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected strobe", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_res.temp_centi !== want.temp_centi)
                    report_mismatch("temp_centi", o_res.temp_centi, want.temp_centi);
                if (o_res.press_q24_8 !== want.press_q24_8)
                    report_mismatch("press_q24_8", o_res.press_q24_8, want.press_q24_8);
                if (o_res.press_invalid !== want.press_invalid)
                    report_mismatch("press_invalid", o_res.press_invalid,
                                    want.press_invalid);
                if (o_res.hum_q22_10 !== want.hum_q22_10)
                    report_mismatch("hum_q22_10", o_res.hum_q22_10, want.hum_q22_10);
                if (want.press_invalid) invalid_seen++;
            end
            checked_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------
    // Send one measurement; start stays high across back-to-back transactions
    task automatic send_meas(t_meas m);
        logic was_busy;
        if (sender_idle_pct > 0) begin
            while ($urandom_range(99) < sender_idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_meas <= m;
        // hold until a rising edge sees start high with busy low
        forever begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy) break;
        end
        pending_results.push_back(compensate(m));
        sent_count++;
    endtask

    // Drop start and wait for every outstanding transaction to come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cal(t_cfg_idx idx, logic [47:0] data);
        case (idx)
            CFG_CAL_HUM_A: data = {16'h0, data[31:0]};
            CFG_CAL_HUM_B: data = {8'h0, data[39:0]};
            default: ;
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cal_shadow[idx] = data;
        // hold the enable low between writes
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic t_meas rand_meas();
        t_meas m;
        m.raw_temp  = 20'($urandom());
        m.raw_press = 20'($urandom());
        m.raw_hum   = 16'($urandom());
        return m;
    endfunction

    // Realistic datasheet-like calibration, so results sit in normal ranges
    task automatic load_typical_cal();
        write_cal(CFG_CAL_TEMP,      {16'hFC18, 16'd26435, 16'd27504});
        write_cal(CFG_CAL_PRESS_LO,  {16'd3024, 16'hD643, 16'd36477});
        write_cal(CFG_CAL_PRESS_MID, {16'hFFF9, 16'd140, 16'd2855});
        write_cal(CFG_CAL_PRESS_HI,  {16'hC6F8, 16'd15500, 16'd6000});
        write_cal(CFG_CAL_HUM_A,     {16'h0, 8'd0, 16'd362, 8'd75});
        write_cal(CFG_CAL_HUM_B,     {8'h0, 8'd30, 16'd50, 16'd313});
    endtask

    task automatic load_fill_cal(logic [47:0] fill);
        write_cal(CFG_CAL_TEMP,      fill);
        write_cal(CFG_CAL_PRESS_LO,  fill);
        write_cal(CFG_CAL_PRESS_MID, fill);
        write_cal(CFG_CAL_PRESS_HI,  fill);
        write_cal(CFG_CAL_HUM_A,     fill);
        write_cal(CFG_CAL_HUM_B,     fill);
    endtask

    task automatic load_random_cal();
        write_cal(CFG_CAL_TEMP,      rand48());
        write_cal(CFG_CAL_PRESS_LO,  rand48());
        write_cal(CFG_CAL_PRESS_MID, rand48());
        write_cal(CFG_CAL_PRESS_HI,  rand48());
        write_cal(CFG_CAL_HUM_A,     rand48());
        write_cal(CFG_CAL_HUM_B,     rand48());
    endtask

    // Corner measurements: every field at zero, at full scale, and mixed
    task automatic send_corners();
        send_meas('{raw_temp: 20'h0,     raw_press: 20'h0,     raw_hum: 16'h0});
        send_meas('{raw_temp: 20'hFFFFF, raw_press: 20'hFFFFF, raw_hum: 16'hFFFF});
        send_meas('{raw_temp: 20'hFFFFF, raw_press: 20'h0,     raw_hum: 16'h0});
        send_meas('{raw_temp: 20'h0,     raw_press: 20'hFFFFF, raw_hum: 16'hFFFF});
        send_meas('{raw_temp: 20'd519888, raw_press: 20'd415148, raw_hum: 16'd30000});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset calibration is all zero, so the pressure divisor is zero here
    task automatic test_reset_calibration();
        sender_idle_pct = 0;
        send_corners();
        drain_results();
    endtask

    task automatic test_typical_calibration();
        load_typical_cal();
        send_corners();
        drain_results();
    endtask

    // Zero P1 forces the divisor to zero; temperature and humidity stay live
    task automatic test_zero_divisor();
        write_cal(CFG_CAL_PRESS_LO, {16'd3024, 16'hD643, 16'd0});
        send_corners();
        drain_results();
    endtask

    // All-ones calibration drives the quotient and clamp limits
    task automatic test_saturating_calibration();
        load_fill_cal('1);
        send_corners();
        drain_results();
        write_cal(CFG_CAL_PRESS_LO, {16'h7FFF, 16'h7FFF, 16'd1});
        write_cal(CFG_CAL_HUM_A,    {16'h0, 8'hFF, 16'h7FFF, 8'hFF});
        send_corners();
        drain_results();
    endtask

    // Random measurements in phases of differing sender idling
    task automatic test_random_phase(int idle_pct, int count, bit rand_cal);
        sender_idle_pct = idle_pct;
        if (rand_cal) load_random_cal();
        else load_typical_cal();
        for (int i = 0; i < count; i++) begin
            // every 50 transactions, swap one register mid-phase after draining
            if (rand_cal && i > 0 && i % 50 == 0) begin
                drain_results();
                write_cal(t_cfg_idx'($urandom_range(5)), rand48());
            end
            send_meas(rand_meas());
        end
        drain_results();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_meas          <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_wdata     <= '0;
        mismatches      = 0;
        sent_count      = 0;
        checked_count   = 0;
        invalid_seen    = 0;
        sender_idle_pct = 0;
        for (int i = 0; i < 6; i++) cal_shadow[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_typical_calibration();
        test_zero_divisor();
        test_saturating_calibration();
        test_random_phase(0,  200, 1'b0);
        test_random_phase(60, 150, 1'b1);
        test_random_phase(0,  150, 1'b1);
        test_random_phase(26, 150, 1'b1);
        test_random_phase(60, 150, 1'b0);

        // tail: let the pipeline run empty to catch stray strobes
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);

        $display("Run covered %0d measurements, %0d results checked, %0d with zero divisor",
                 sent_count, checked_count, invalid_seen);
        $display("Calibration sets: reset, typical, all-ones, saturating, random");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
